FILE: sv/multichannel_scan_ema_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multichannel scan EMA filter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SCAN_EMA_FILTER_UNIT_MACROS_SVH
`define MULTICHANNEL_SCAN_EMA_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// check that is masked while reset is asserted
`define MSEF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds during reset
`define MSEF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSEF_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSEF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/msef_pkg.sv
// ----------------------------------------------------------------------------
// msef_pkg
// Types and constants shared by the multichannel scan EMA filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msef_pkg;

	localparam int MAX_SLOTS            = 18;
	localparam int NUM_CH               = 18;
	localparam int SAMPLE_SCALE         = 19;
	localparam int DEFAULT_FILTER_SHIFT = 9;
	localparam int DEFAULT_OUT_SHIFT    = 15;

	localparam int KIND_W   = 2;
	localparam int SAMPLE_W = 12;
	localparam int CH_W     = 5;
	localparam int SHIFT_W  = 5;
	localparam int VALUE_W  = 16;
	localparam int ACC_W    = 32;

	localparam int SLOT_IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
	localparam int CH_IDX_W   = $clog2(NUM_CH);

	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SAMPLE_W-1:0] sample;
		logic [CH_W-1:0]     pin;
		logic [SHIFT_W-1:0]  filter_shift;
		logic [SHIFT_W-1:0]  out_shift;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic [VALUE_W-1:0] value;
		logic [CH_W-1:0]    next_channel;
		logic               added;
	} out_item_t;

	// slot table view handed to the channel bank and the result stage
	typedef struct packed {
		logic [CH_W-1:0]    cur_ch;
		logic [SHIFT_W-1:0] cur_fs;
		logic [CH_W-1:0]    next_ch;
		logic               added;
	} slot_info_t;

	// channel bank lookup result
	typedef struct packed {
		logic [ACC_W-1:0]   acc;
		logic [SHIFT_W-1:0] oshift;
		logic               hit;
	} chan_rsp_t;

endpackage

`default_nettype wire

FILE: sv/msef_if.sv
// ----------------------------------------------------------------------------
// msef_in_if / msef_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface msef_in_if
	import msef_pkg::*;
	;
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface msef_out_if
	import msef_pkg::*;
	;
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/msef_slot_ctrl.sv
// ----------------------------------------------------------------------------
// msef_slot_ctrl
// Scan slot table, slot index and count; tracks the channel to convert next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_scan_ema_filter_unit_macros.svh"

module msef_slot_ctrl
	import msef_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               commit,
	input  wire logic [KIND_W-1:0]  kind,
	input  wire logic [CH_W-1:0]    pin,
	input  wire logic [SHIFT_W-1:0] filter_shift,
	output slot_info_t              info
);

	logic [CH_W-1:0]       slot_ch_q [MAX_SLOTS];
	logic [SHIFT_W-1:0]    slot_fs_q [MAX_SLOTS];
	logic [SLOT_IDX_W-1:0] index_q;
	logic [SLOT_CNT_W-1:0] count_q;
	logic [CH_W-1:0]       cur_ch_q;
	logic [SHIFT_W-1:0]    cur_fs_q;

	logic                  add_ok;
	logic [SLOT_CNT_W-1:0] idx_inc;
	logic [SLOT_IDX_W-1:0] next_idx;
	logic                  fwd;
	logic [CH_W-1:0]       next_ch;
	logic [SHIFT_W-1:0]    next_fs;

	always_comb begin
		add_ok  = (kind == KIND_ADD) && (count_q < SLOT_CNT_W'(MAX_SLOTS))
			&& (pin < CH_W'(NUM_CH));
		idx_inc = SLOT_CNT_W'(index_q) + SLOT_CNT_W'(1);
		if (kind == KIND_SAMPLE) begin
			next_idx = (idx_inc >= count_q) ? '0 : idx_inc[SLOT_IDX_W-1:0];
		end else begin
			next_idx = index_q;
		end
		// an add into the slot that becomes current is seen right away
		fwd     = add_ok && (count_q == SLOT_CNT_W'(next_idx));
		next_ch = fwd ? pin : slot_ch_q[next_idx];
		next_fs = fwd ? filter_shift : slot_fs_q[next_idx];

		info.cur_ch  = cur_ch_q;
		info.cur_fs  = cur_fs_q;
		info.next_ch = next_ch;
		info.added   = add_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				slot_ch_q[i] <= '0;
				slot_fs_q[i] <= SHIFT_W'(DEFAULT_FILTER_SHIFT);
			end
			index_q  <= '0;
			count_q  <= '0;
			cur_ch_q <= '0;
			cur_fs_q <= SHIFT_W'(DEFAULT_FILTER_SHIFT);
		end else if (commit) begin
			if (add_ok) begin
				slot_ch_q[count_q[SLOT_IDX_W-1:0]] <= pin;
				slot_fs_q[count_q[SLOT_IDX_W-1:0]] <= filter_shift;
				count_q <= count_q + SLOT_CNT_W'(1);
			end
			index_q  <= next_idx;
			cur_ch_q <= next_ch;
			cur_fs_q <= next_fs;
		end
	end

	`MSEF_ASSERT_ALWAYS(a_count_bound, clk, count_q <= SLOT_CNT_W'(MAX_SLOTS), "slot count over max")
	`MSEF_ASSERT(a_index_in_table, clk, arst_n, count_q == '0 || SLOT_CNT_W'(index_q) < count_q, "slot index outside table")
	`MSEF_ASSERT(a_cur_tracks_table, clk, arst_n, count_q == '0 || cur_ch_q == slot_ch_q[index_q], "current channel out of step")

endmodule

`default_nettype wire

FILE: sv/msef_chan_bank.sv
// ----------------------------------------------------------------------------
// msef_chan_bank
// Per-channel accumulators and output shifts with the EMA update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msef_chan_bank
	import msef_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                commit,
	input  wire logic [KIND_W-1:0]   kind,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic [CH_W-1:0]     pin,
	input  wire logic [SHIFT_W-1:0]  out_shift,
	input  slot_info_t               info,
	output chan_rsp_t                rsp
);

	logic [ACC_W-1:0]   acc_q    [NUM_CH];
	logic [SHIFT_W-1:0] oshift_q [NUM_CH];

	logic                is_sample;
	logic [CH_W-1:0]     addr;
	logic                in_range;
	logic [CH_IDX_W-1:0] idx;
	logic [ACC_W-1:0]    acc_cur;
	logic [ACC_W-1:0]    x;
	logic [ACC_W-1:0]    diff;
	logic [ACC_W-1:0]    step;
	logic [ACC_W-1:0]    acc_new;

	always_comb begin
		is_sample = (kind == KIND_SAMPLE);
		addr      = is_sample ? info.cur_ch : pin;
		in_range  = addr < CH_W'(NUM_CH);
		idx       = in_range ? addr[CH_IDX_W-1:0] : '0;
		acc_cur   = acc_q[idx];
		// scaled sample fits in the accumulator width
		x         = ACC_W'(sample) << SAMPLE_SCALE;
		diff      = x - acc_cur;
		step      = $unsigned($signed(diff) >>> info.cur_fs);
		acc_new   = acc_cur + step;

		rsp.acc    = is_sample ? acc_new : acc_cur;
		rsp.oshift = oshift_q[idx];
		rsp.hit    = in_range && (is_sample || kind == KIND_READ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CH; i++) begin
				acc_q[i]    <= '0;
				oshift_q[i] <= SHIFT_W'(DEFAULT_OUT_SHIFT);
			end
		end else if (commit) begin
			if (is_sample && in_range) begin
				acc_q[idx] <= acc_new;
			end
			if (info.added) begin
				oshift_q[pin[CH_IDX_W-1:0]] <= out_shift;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/multichannel_scan_ema_filter_unit.sv
// ----------------------------------------------------------------------------
// multichannel_scan_ema_filter_unit
// Round-robin multichannel conversion filter with per-channel moving average.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns exactly one result per item,
// passing through an input register, then a result register that
// decouples the result side. Sample, add and read items all finish in the
// single cycle between those registers, so slot table and accumulator
// updates are visible to the very next item. Full throughput holds as long
// as results are taken; a stalled result holds the input register, and the
// input side stops only when both registers are full.
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_scan_ema_filter_unit_macros.svh"

module multichannel_scan_ema_filter_unit
	import msef_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	msef_in_if.sink     req,
	msef_out_if.source  rsp
);

	logic       s1_valid_q;
	in_item_t   item_s1;

	logic               s2_valid_q;
	logic [CH_W-1:0]    ch_s2;
	logic [ACC_W-1:0]   acc_s2;
	logic [SHIFT_W-1:0] osh_s2;
	logic               hit_s2;
	logic [CH_W-1:0]    next_s2;
	logic               added_s2;

	logic       s2_free;
	logic       commit;
	slot_info_t info;
	chan_rsp_t  bank;
	logic [CH_W-1:0]  res_ch;
	logic [ACC_W-1:0] shifted;

	assign s2_free   = !s2_valid_q || rsp.ready;
	assign commit    = s1_valid_q && s2_free;
	assign req.ready = !s1_valid_q || s2_free;

	msef_slot_ctrl u_slot (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.kind         (item_s1.kind),
		.pin          (item_s1.pin),
		.filter_shift (item_s1.filter_shift),
		.info         (info)
	);

	msef_chan_bank u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (commit),
		.kind      (item_s1.kind),
		.sample    (item_s1.sample),
		.pin       (item_s1.pin),
		.out_shift (item_s1.out_shift),
		.info      (info),
		.rsp       (bank)
	);

	always_comb begin
		case (item_s1.kind)
			KIND_SAMPLE: res_ch = info.cur_ch;
			KIND_ADD,
			KIND_READ:   res_ch = item_s1.pin;
			default:     res_ch = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				s1_valid_q <= 1'b1;
			end else if (commit) begin
				s1_valid_q <= 1'b0;
			end
			if (commit) begin
				s2_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (commit) begin
			ch_s2    <= res_ch;
			acc_s2   <= bank.acc;
			osh_s2   <= bank.oshift;
			hit_s2   <= bank.hit;
			next_s2  <= info.next_ch;
			added_s2 <= info.added;
		end
	end

	// output scaling sits after the result register
	assign shifted = $unsigned($signed(acc_s2) >>> osh_s2);

	assign rsp.valid             = s2_valid_q;
	assign rsp.data.channel      = ch_s2;
	assign rsp.data.value        = hit_s2 ? shifted[VALUE_W-1:0] : '0;
	assign rsp.data.next_channel = next_s2;
	assign rsp.data.added        = added_s2;

	`MSEF_ASSERT(a_ready_when_drained, clk, arst_n, !s2_valid_q |-> req.ready, "input blocked with empty result stage")
	`MSEF_ASSERT(a_add_has_no_value, clk, arst_n, s2_valid_q && added_s2 |-> !hit_s2, "add result carries a value")
	`MSEF_ASSERT(a_next_in_range, clk, arst_n, s2_valid_q |-> next_s2 < CH_W'(NUM_CH), "next channel out of range")
	`MSEF_ASSERT(a_stall_holds_input, clk, arst_n, s1_valid_q && !s2_free |=> s1_valid_q && $stable(item_s1), "input item lost on stall")

endmodule

`default_nettype wire

FILE: tb/multichannel_scan_ema_filter_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_scan_ema_filter_unit_test
// Self-checking bench for the round-robin scan filter. A short directed table
// covers reset state, rejected adds, the empty and growing slot table and
// shift extremes. Random traffic then builds the table to full and exercises
// sampling, reads and rejected adds. Each result is compared against a fixed
// expected value or an in-bench model of the slot table and the channel accumulators.
// ----------------------------------------------------------------------------

module multichannel_scan_ema_filter_unit_test;
	import msef_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 1330;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned CYCLE_LIMIT  = 400000;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t result;
	} vector_t;

	logic clk;
	logic arst_n;

	msef_in_if  in_ch ();
	msef_out_if out_ch ();

	multichannel_scan_ema_filter_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (in_ch),
		.rsp    (out_ch)
	);

	// model state
	logic [CH_W-1:0]    slot_ch  [MAX_SLOTS];
	logic [SHIFT_W-1:0] slot_fs  [MAX_SLOTS];
	logic [SHIFT_W-1:0] ch_os    [NUM_CH];
	logic [ACC_W-1:0]   chan_acc [NUM_CH];
	int unsigned        slot_idx;
	int unsigned        slot_cnt;

	out_item_t   pending_results [$];
	int unsigned error_count;
	int unsigned results_checked;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [VALUE_W-1:0] channel_reading(input logic [CH_W-1:0] ch);
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] shifted;
		if (ch >= NUM_CH)
			return '0;
		acc     = chan_acc[ch];
		shifted = acc >>> ch_os[ch];
		return shifted[VALUE_W-1:0];
	endfunction

	function automatic out_item_t predict_scan_result(input in_item_t it);
		out_item_t               res;
		logic [CH_W-1:0]         ch;
		logic [ACC_W-1:0]        x;
		logic [ACC_W-1:0]        diff;
		logic signed [ACC_W-1:0] step;
		int unsigned             s;
		res = '0;
		case (it.kind)
			KIND_SAMPLE: begin
				s  = slot_idx;
				ch = slot_ch[s];
				if (ch < NUM_CH) begin
					x    = {{(ACC_W - SAMPLE_W){1'b0}}, it.sample} << SAMPLE_SCALE;
					diff = x - chan_acc[ch];
					// separate signed step keeps the shift arithmetic
					step = $signed(diff) >>> slot_fs[s];
					chan_acc[ch] = chan_acc[ch] + step;
				end
				s++;
				if (s >= slot_cnt)
					s = 0;
				slot_idx    = s;
				res.channel = ch;
				res.value   = channel_reading(ch);
			end
			KIND_ADD: begin
				res.channel = it.pin;
				if (slot_cnt < MAX_SLOTS && it.pin < NUM_CH) begin
					slot_ch[slot_cnt] = it.pin;
					slot_fs[slot_cnt] = it.filter_shift;
					ch_os[it.pin]     = it.out_shift;
					slot_cnt++;
					res.added = 1'b1;
				end
			end
			KIND_READ: begin
				res.channel = it.pin;
				res.value   = channel_reading(it.pin);
			end
			default: ;
		endcase
		res.next_channel = slot_ch[slot_idx];
		return res;
	endfunction

	function automatic vector_t make_vector(input logic [KIND_W-1:0] kind, input int smp,
			input int pin, input int fs, input int os, input bit typed, input int ch,
			input int val, input int nxt, input int add);
		vector_t v;
		v.item.kind          = kind;
		v.item.sample        = smp[SAMPLE_W-1:0];
		v.item.pin           = pin[CH_W-1:0];
		v.item.filter_shift  = fs[SHIFT_W-1:0];
		v.item.out_shift     = os[SHIFT_W-1:0];
		v.typed              = typed;
		v.result.channel     = ch[CH_W-1:0];
		v.result.value       = val[VALUE_W-1:0];
		v.result.next_channel = nxt[CH_W-1:0];
		v.result.added       = add[0];
		return v;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned gap_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	function automatic in_item_t random_item();
		in_item_t    it;
		int unsigned r;
		it = in_item_t'($urandom);
		r  = $urandom_range(0, 99);
		if (r < 20) begin
			it.kind = KIND_READ;
			it.pin  = ($urandom_range(0, 99) < 6) ? CH_W'($urandom_range(18, 31))
				: CH_W'($urandom_range(0, 17));
		end else if (r < 28) begin
			it.kind = KIND_ADD;
			it.pin  = ($urandom_range(0, 99) < 8) ? CH_W'($urandom_range(18, 31))
				: CH_W'($urandom_range(0, 17));
			if ($urandom_range(0, 99) < 70)
				it.filter_shift = SHIFT_W'($urandom_range(0, 8));
			if ($urandom_range(0, 1))
				it.out_shift = SHIFT_W'($urandom_range(10, 20));
		end else if (r < 31) begin
			it.kind = KIND_UNUSED;
		end else begin
			it.kind = KIND_SAMPLE;
			r = $urandom_range(0, 99);
			if (r < 10)
				it.sample = '0;
			else if (r < 20)
				it.sample = '1;
		end
		return it;
	endfunction

	task automatic flag_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic hold_input(input int unsigned n);
		@(negedge clk);
		in_ch.valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drive_item(input in_item_t it, input bit typed, input out_item_t typed_res);
		out_item_t predicted;
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.data  = it;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predicted = predict_scan_result(it);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		out_item_t got;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got = out_ch.data;
			results_checked++;
			if (pending_results.size() == 0) begin
				flag_error($sformatf("unexpected result ch=%0d val=%h next=%0d add=%0b",
					got.channel, got.value, got.next_channel, got.added));
			end else begin
				want = pending_results.pop_front();
				if (got.channel !== want.channel || got.value !== want.value ||
						got.next_channel !== want.next_channel ||
						got.added !== want.added)
					flag_error($sformatf({"mismatch exp ch=%0d val=%h next=%0d add=%0b",
						" got ch=%0d val=%h next=%0d add=%0b"},
						want.channel, want.value, want.next_channel, want.added,
						got.channel, got.value, got.next_channel, got.added));
			end
		end
	end

	initial begin : result_ready
		int unsigned stall_left;
		bit          held;
		stall_left = 0;
		held       = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else begin
				out_ch.ready = 1'b1;
				// one long back-pressure stretch so both pipeline stages fill
				if (!held && results_checked >= 500) begin
					held       = 1'b1;
					stall_left = HOLD_CYCLES;
				end else if (!no_idle && $urandom_range(0, 99) < 20) begin
					stall_left = gap_length();
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		vector_t   directed [$];
		vector_t   v;
		out_item_t none;
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.data      = '0;
		out_ch.ready    = 1'b0;
		no_idle         = 1'b0;
		error_count     = 0;
		results_checked = 0;
		none            = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			slot_ch[i] = '0;
			slot_fs[i] = SHIFT_W'(DEFAULT_FILTER_SHIFT);
		end
		for (int i = 0; i < NUM_CH; i++) begin
			ch_os[i]    = SHIFT_W'(DEFAULT_OUT_SHIFT);
			chan_acc[i] = '0;
		end
		slot_idx = 0;
		slot_cnt = 0;

		// reset state, out-of-range pins, unused kind
		directed.push_back(make_vector(KIND_READ,      0,  0,  0,  0, 1,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_READ,      0, 17,  0,  0, 1, 17, 0,  0, 0));
		directed.push_back(make_vector(KIND_READ,      0, 31,  0,  0, 1, 31, 0,  0, 0));
		directed.push_back(make_vector(KIND_UNUSED, 4095, 31, 31, 31, 1,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_ADD,       0, 31,  5,  5, 1, 31, 0,  0, 0));
		directed.push_back(make_vector(KIND_ADD,       0, 18,  0,  0, 1, 18, 0,  0, 0));
		// empty table: slot 0 as reset left it
		directed.push_back(make_vector(KIND_SAMPLE, 4095,  0,  0,  0, 1,  0, 127, 0, 0));
		directed.push_back(make_vector(KIND_SAMPLE,    0,  0,  0,  0, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_READ,      0,  0,  0,  0, 0,  0, 0,  0, 0));
		// shift extremes: zero filter shift loads the sample outright
		directed.push_back(make_vector(KIND_ADD,       0, 17,  0,  0, 1, 17, 0, 17, 1));
		directed.push_back(make_vector(KIND_SAMPLE, 4095,  0,  0,  0, 1, 17, 0, 17, 0));
		directed.push_back(make_vector(KIND_READ,      0, 17,  0,  0, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_ADD,       0, 16, 31, 31, 1, 16, 0, 17, 1));
		directed.push_back(make_vector(KIND_SAMPLE,    0,  0,  0,  0, 1, 17, 0, 16, 0));
		directed.push_back(make_vector(KIND_SAMPLE, 4095,  0,  0,  0, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_ADD,       0,  0,  1, 16, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_SAMPLE, 'hAAA, 0,  0,  0, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_SAMPLE, 'h555, 0,  0,  0, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_SAMPLE, 4095,  0,  0,  0, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_READ,      0, 16,  0,  0, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_ADD,       0,  1,  9, 12, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_SAMPLE, 'h800, 0,  0,  0, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_READ,      0,  1,  0,  0, 0,  0, 0,  0, 0));
		directed.push_back(make_vector(KIND_READ,      0,  0,  0,  0, 0,  0, 0,  0, 0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			v = directed[i];
			if ($urandom_range(0, 99) < 25)
				hold_input(gap_length());
			drive_item(v.item, v.typed, v.result);
		end

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			no_idle = (n >= 900 && n < 1100);
			if (n == 300) begin
				// let the result side run dry before going on
				@(negedge clk);
				in_ch.valid = 1'b0;
				wait (pending_results.size() == 0);
			end else if (!no_idle && $urandom_range(0, 99) < 25) begin
				hold_input(gap_length());
			end
			drive_item(random_item(), 1'b0, none);
		end
		no_idle = 1'b0;

		@(negedge clk);
		in_ch.valid = 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", pending_results.size()));

		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+sv
sv/msef_pkg.sv
sv/msef_if.sv
sv/msef_slot_ctrl.sv
sv/msef_chan_bank.sv
sv/multichannel_scan_ema_filter_unit.sv
tb/multichannel_scan_ema_filter_unit_test.sv
